// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file brg_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is active.
`define BRG_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("bearing check failed");

// Clocked check that also runs during reset.
`define BRG_ASSERT_NR(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("bearing check failed during reset");

`endif

// ===== rtl/core/brg_pkg.sv =====
package brg_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 23;
    localparam int NORM_BITS    = 58;
    localparam int SH_W         = $clog2(NORM_BITS + 1);
    localparam int XW           = 62;   // rotation datapath, holds 2^58 * gain * sqrt(2)
    localparam int ZW           = 26;   // angle accumulator, holds 360 deg in signed 10.16
    localparam int DEG_W        = 9;
    localparam int OUT_TDATA_W  = 16;

    typedef logic signed [XW-1:0] t_vec;
    typedef logic signed [ZW-1:0] t_ang;

    localparam logic [DEG_W-1:0] DEG_0   = 9'd0;
    localparam logic [DEG_W-1:0] DEG_90  = 9'd90;
    localparam logic [DEG_W-1:0] DEG_180 = 9'd180;
    localparam logic [DEG_W-1:0] DEG_270 = 9'd270;
    localparam logic [DEG_W-1:0] DEG_MAX = 9'd359;

    localparam t_ang ANG_45    = t_ang'(45 * 65536);
    localparam t_ang ANG_180   = t_ang'(180 * 65536);
    localparam t_ang ANG_360   = t_ang'(360 * 65536);
    localparam t_ang THETA_MIN = t_ang'(1);
    localparam t_ang THETA_MAX = t_ang'(90 * 65536 - 1);

    // atan(2^-i) in degrees, 16 fraction bits
    localparam t_ang ATAN_DEG [CORDIC_STEPS] = '{
        t_ang'(2949120), t_ang'(1740967), t_ang'(919879), t_ang'(466945),
        t_ang'(234379),  t_ang'(117304),  t_ang'(58666),  t_ang'(29335),
        t_ang'(14668),   t_ang'(7334),    t_ang'(3667),   t_ang'(1833),
        t_ang'(917),     t_ang'(458),     t_ang'(229),    t_ang'(115),
        t_ang'(57),      t_ang'(29),      t_ang'(14),     t_ang'(7),
        t_ang'(4),       t_ang'(2),       t_ang'(1)
    };

    typedef struct packed {
        logic             dx_neg;
        logic             dy_neg;
        logic             special;   // axis-aligned offset, answer known up front
        logic             eq;        // equal magnitudes, exactly 45 degrees
        logic [DEG_W-1:0] spec_deg;
    } t_side;

endpackage

// ===== rtl/core/bearing_angle_degrees.sv =====
// Channel    | Dir | Port group                | Content
// -----------+-----+---------------------------+----------------------------------------
// point pair | in  | i_s_tvalid/o_s_tready     | i_s_tdata: base_x, base_y, target_x,
//            |     |                           | target_y (COORD_BITS each, signed)
// bearing    | out | o_m_tvalid/i_m_tready     | o_m_tdata: bearing_deg (9 bits)
//
// One transaction per cycle sustained while the output is not stalled; the pipeline
// holds 23 rotation stages, each a single add/subtract on the 62-bit vector.
// Reset (i_rst_n low, synchronous) clears every stage valid bit; data regs are not reset.
// Each stage advances when it is empty or the stage after it advances, so a stall
// on the output squeezes out bubbles first and then holds o_s_tready low.
module bearing_angle_degrees #(
    parameter int COORD_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_tvalid,
    output logic                                     o_s_tready,
    // base_x, base_y, target_x, target_y from bit 0 up; zero pad to a byte
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]        i_s_tdata,
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    // bearing_deg in [8:0], zeros above
    output logic [brg_pkg::OUT_TDATA_W-1:0]          o_m_tdata
);

    localparam int DW = COORD_BITS + 1;          // offset width
    localparam int LW = $clog2(DW + 1);          // bit-length width
    localparam int NS = brg_pkg::CORDIC_STEPS;
    localparam int NV = NS + 5;                  // stages carrying a valid bit

    // Stage map: 0 diff, 1 abs/classify, 2 length, 3 normalize,
    // 4..NS+3 rotations, NS+4 output register.
    logic [NV-1:0] r_v;
    logic [NV-1:0] w_rdy;

    assign w_rdy[NV-1] = !r_v[NV-1] || i_m_tready;
    for (genvar j = 0; j < NV - 1; j++) begin : g_rdy
        assign w_rdy[j] = !r_v[j] || w_rdy[j+1];
    end

    assign o_s_tready = w_rdy[0];
    assign o_m_tvalid = r_v[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_s_tvalid;
            end
            for (int j = 1; j < NV; j++) begin
                if (w_rdy[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    // ---------------- stage 0: offsets ----------------
    logic signed [COORD_BITS-1:0] w_bx, w_by, w_tx, w_ty;
    logic signed [DW-1:0]         r_dx, r_dy;

    assign w_bx = i_s_tdata[0*COORD_BITS +: COORD_BITS];
    assign w_by = i_s_tdata[1*COORD_BITS +: COORD_BITS];
    assign w_tx = i_s_tdata[2*COORD_BITS +: COORD_BITS];
    assign w_ty = i_s_tdata[3*COORD_BITS +: COORD_BITS];

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_dx <= DW'(w_tx) - DW'(w_bx);
            r_dy <= DW'(w_ty) - DW'(w_by);
        end
    end

    // ---------------- stage 1: magnitudes, axis cases ----------------
    logic [DW-1:0]  n_ax1, n_ay1, r_ax1, r_ay1;
    brg_pkg::t_side n_side1, r_side1;

    always_comb begin
        n_ax1 = r_dx[DW-1] ? DW'(-r_dx) : r_dx;
        n_ay1 = r_dy[DW-1] ? DW'(-r_dy) : r_dy;
        n_side1          = '0;
        n_side1.dx_neg   = r_dx[DW-1];
        n_side1.dy_neg   = r_dy[DW-1];
        n_side1.spec_deg = brg_pkg::DEG_0;
        if (r_dx == '0) begin
            // straight up gives 90; down, or no offset at all, gives 270
            n_side1.special  = 1'b1;
            n_side1.spec_deg = (!r_dy[DW-1] && r_dy != '0) ? brg_pkg::DEG_90
                                                            : brg_pkg::DEG_270;
        end else if (r_dy == '0) begin
            n_side1.special  = 1'b1;
            n_side1.spec_deg = r_dx[DW-1] ? brg_pkg::DEG_180 : brg_pkg::DEG_0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_ax1   <= n_ax1;
            r_ay1   <= n_ay1;
            r_side1 <= n_side1;
        end
    end

    // ---------------- stage 2: bit length of the larger magnitude ----------------
    logic [DW-1:0]            n_m;
    logic [LW-1:0]            n_len;
    logic [brg_pkg::SH_W-1:0] r_sh;
    logic [DW-1:0]            r_ax2, r_ay2;
    brg_pkg::t_side           n_side2, r_side2;

    always_comb begin
        n_m   = (r_ax1 > r_ay1) ? r_ax1 : r_ay1;
        n_len = '0;
        for (int i = 0; i < DW; i++) begin
            if (n_m[i]) begin
                n_len = LW'(i + 1);
            end
        end
        n_side2    = r_side1;
        n_side2.eq = (r_ax1 == r_ay1);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_sh    <= brg_pkg::SH_W'(brg_pkg::NORM_BITS - int'(n_len));
            r_ax2   <= r_ax1;
            r_ay2   <= r_ay1;
            r_side2 <= n_side2;
        end
    end

    // ---------------- stage 3 and rotations ----------------
    brg_pkg::t_vec  r_x    [0:NS];
    brg_pkg::t_vec  r_y    [0:NS];
    brg_pkg::t_ang  r_z    [0:NS];
    brg_pkg::t_side r_side [0:NS];

    // Scale both magnitudes up so the larger one is NORM_BITS long.
    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_x[0]    <= brg_pkg::t_vec'(brg_pkg::XW'(r_ax2) << r_sh);
            r_y[0]    <= brg_pkg::t_vec'(brg_pkg::XW'(r_ay2) << r_sh);
            r_z[0]    <= '0;
            r_side[0] <= r_side2;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_rot
        brg_pkg::t_vec w_xs, w_ys;
        assign w_xs = r_x[k] >>> k;
        assign w_ys = r_y[k] >>> k;

        // Rotate toward the x axis; direction follows the sign of y.
        always_ff @(posedge i_clk) begin
            if (w_rdy[4+k]) begin
                if (r_y[k][brg_pkg::XW-1]) begin
                    r_x[k+1] <= r_x[k] - w_ys;
                    r_y[k+1] <= r_y[k] + w_xs;
                    r_z[k+1] <= r_z[k] - brg_pkg::ATAN_DEG[k];
                end else begin
                    r_x[k+1] <= r_x[k] + w_ys;
                    r_y[k+1] <= r_y[k] - w_xs;
                    r_z[k+1] <= r_z[k] + brg_pkg::ATAN_DEG[k];
                end
                r_side[k+1] <= r_side[k];
            end
        end
    end

    // ---------------- output stage: clamp, unfold quadrant ----------------
    brg_pkg::t_ang                 n_theta, n_full;
    logic [brg_pkg::DEG_W-1:0]     n_deg, r_deg;
    brg_pkg::t_side                w_sf;

    assign w_sf = r_side[NS];

    always_comb begin
        if (w_sf.eq) begin
            n_theta = brg_pkg::ANG_45;
        end else if (r_z[NS] < brg_pkg::THETA_MIN) begin
            n_theta = brg_pkg::THETA_MIN;
        end else if (r_z[NS] > brg_pkg::THETA_MAX) begin
            n_theta = brg_pkg::THETA_MAX;
        end else begin
            n_theta = r_z[NS];
        end
        case ({w_sf.dx_neg, w_sf.dy_neg})
            2'b00:   n_full = n_theta;
            2'b10:   n_full = brg_pkg::ANG_180 - n_theta;
            2'b11:   n_full = brg_pkg::ANG_180 + n_theta;
            default: n_full = brg_pkg::ANG_360 - n_theta;
        endcase
        n_deg = w_sf.special ? w_sf.spec_deg
                             : n_full[brg_pkg::FRAC_BITS +: brg_pkg::DEG_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NV-1]) begin
            r_deg <= n_deg;
        end
    end

    assign o_m_tdata = brg_pkg::OUT_TDATA_W'(r_deg);

endmodule

// ===== rtl/core/brg_chk.sv =====
`include "assert_macros.svh"

module brg_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [brg_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    logic w_deg_ok;
    logic w_pad_ok;

    assign w_deg_ok = (o_m_tdata[brg_pkg::DEG_W-1:0] <= brg_pkg::DEG_MAX);
    assign w_pad_ok = (o_m_tdata[brg_pkg::OUT_TDATA_W-1:brg_pkg::DEG_W] == '0);

    // a stalled result stays offered
    `BRG_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid)

    // bearing is always a legal whole degree with clean pad bits
    `BRG_ASSERT(a_out_range, i_clk, i_rst_n, o_m_tvalid |-> w_deg_ok && w_pad_ok)

    // a waiting transaction is held off only while the output is stalled
    `BRG_ASSERT(a_in_stall_full, i_clk, i_rst_n, i_s_tvalid && !o_s_tready |-> o_m_tvalid && !i_m_tready)

    // reset empties the pipe
    `BRG_ASSERT_NR(a_reset_clears, i_clk, !i_rst_n |=> !o_m_tvalid)

endmodule

bind bearing_angle_degrees brg_chk u_brg_chk (.*);
